FILE: rtl/core/mmh_pkg.sv
package mmh_pkg;

    // Block and finalizer constants of the 32-bit hash.
    localparam logic [31:0] MIX_C1    = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2    = 32'h1b873593;
    localparam logic [31:0] ROUND_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_C1    = 32'h85ebca6b;
    localparam logic [31:0] FIN_C2    = 32'hc2b2ae35;

    // Number of shards that the hash is spread over (1 to 4).
    localparam int unsigned SHARD_COUNT = 4;

    // One input word of the key.
    typedef struct packed {
        logic [31:0] key_word;
        logic [2:0]  byte_count;
        logic        last;
    } t_key_in;

    // One finished hash result.
    typedef struct packed {
        logic [31:0] hash_value;
        logic [1:0]  shard_index;
    } t_hash_out;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX1,
        ST_MIX2,
        ST_ROUND,
        ST_TAIL,
        ST_FIN0,
        ST_FIN1,
        ST_FIN2,
        ST_FOLD,
        ST_SHARD
    } t_state;

    // Left rotation by a fixed, nonzero amount.
    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

endpackage

FILE: rtl/core/murmur3_key_hash.sv
// Streaming 32-bit MurmurHash3 (seed 0) with shard selection.
// Input channel: i_valid / o_ready carry one key word per transfer in i_data.
// Words before the last always count as four bytes; the last word carries
// zero to four bytes, low byte first. Output channel: o_valid / i_ready carry
// the hash and its shard index, one result per key.
// A single 32x32 multiplier is shared by every multiply step under a small
// sequencer, and o_ready is high only while the sequencer is idle.
// A word that is not last passes through transfer, two multiplies and the round step.
// A last word with one to four bytes passes through two multiplies and the round or
// tail step, and an empty last word skips them; both then take three finalizer steps
// and two steps that fold the hash down to its shard remainder, the last of which
// loads the output register. The next word can transfer once the sequencer is idle.
// The result sits in an output register, so the next key may start while it
// waits. A stalled receiver holds the result; a following key then waits in
// its last step until the register is free.
// Synchronous reset clears the running hash, the length and the output valid.
module murmur3_key_hash #(
    parameter int unsigned SHARD_COUNT = mmh_pkg::SHARD_COUNT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mmh_pkg::t_key_in   i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output mmh_pkg::t_hash_out o_data
);
    import mmh_pkg::*;

    // Weight of each bit position modulo the shard count, four bits per entry.
    function automatic logic [127:0] bit_weights();
        logic [127:0] wts;
        int unsigned  w;
        wts = '0;
        w   = 1 % SHARD_COUNT;
        for (int j = 0; j < 32; j++) begin
            wts[4*j +: 4] = 4'(w);
            w = (2 * w) % SHARD_COUNT;
        end
        return wts;
    endfunction

    localparam logic [7:0]   SHARD_N     = 8'(SHARD_COUNT);
    localparam logic [127:0] BIT_WEIGHTS = bit_weights();

    t_state      r_state, n_state;
    logic [31:0] r_h, n_h;
    logic [31:0] r_len, n_len;
    logic [31:0] r_k, n_k;
    logic        r_last, n_last;
    logic        r_full, n_full;
    logic [8:0]  r_fold, n_fold;
    t_hash_out   r_out, n_out;
    logic        r_out_valid, n_out_valid;

    logic [31:0] mul_a, mul_b, mul_p;
    logic [2:0]  cnt_sat;
    logic        in_full;
    logic [31:0] in_mask;
    logic        out_free;
    logic [8:0]  fold_h;
    logic [7:0]  fold_r;
    logic [7:0]  rem_tmp;
    logic [31:0] mix_x;

    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;
    assign out_free = !r_out_valid || i_ready;

    // Decode of the incoming word: saturated count, block or tail, byte mask.
    always_comb begin
        cnt_sat = (i_data.byte_count > 3'd4) ? 3'd4 : i_data.byte_count;
        in_full = !i_data.last || (cnt_sat == 3'd4);
        for (int b = 0; b < 4; b++) begin
            in_mask[8*b +: 8] = (in_full || (3'(b) < cnt_sat)) ? 8'hff : 8'h00;
        end
    end

    // Shared multiplier; operands are chosen by the sequencer state.
    always_comb begin
        mul_a = r_h;
        mul_b = FIN_C1;
        unique case (r_state)
            ST_MIX1: begin
                mul_a = r_k;
                mul_b = MIX_C1;
            end
            ST_MIX2: begin
                mul_a = rotl32(r_k, 15);
                mul_b = MIX_C2;
            end
            ST_FIN2: begin
                mul_a = r_h;
                mul_b = FIN_C2;
            end
            default: begin
                mul_a = r_h;
                mul_b = FIN_C1;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Shard remainder: the hash is folded by bit weights into a small value
    // with the same remainder, folded once more, and then reduced.
    always_comb begin
        fold_h = '0;
        for (int j = 0; j < 32; j++) begin
            if (r_h[j]) begin
                fold_h = fold_h + 9'(BIT_WEIGHTS[4*j +: 4]);
            end
        end
        fold_r = '0;
        for (int j = 0; j < 9; j++) begin
            if (r_fold[j]) begin
                fold_r = fold_r + 8'(BIT_WEIGHTS[4*j +: 4]);
            end
        end
        rem_tmp = fold_r;
        for (int s = 3; s >= 0; s--) begin
            if (rem_tmp >= (SHARD_N << s)) begin
                rem_tmp = rem_tmp - (SHARD_N << s);
            end
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_data.last && (cnt_sat == 3'd0)) begin
                        n_state = ST_FIN0;
                    end else begin
                        n_state = ST_MIX1;
                    end
                end
            end
            ST_MIX1:  n_state = ST_MIX2;
            ST_MIX2:  n_state = r_full ? ST_ROUND : ST_TAIL;
            ST_ROUND: n_state = r_last ? ST_FIN0 : ST_IDLE;
            ST_TAIL:  n_state = ST_FIN0;
            ST_FIN0:  n_state = ST_FIN1;
            ST_FIN1:  n_state = ST_FIN2;
            ST_FIN2:  n_state = ST_FOLD;
            ST_FOLD:  n_state = ST_SHARD;
            ST_SHARD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Datapath and output register updates for each state.
    always_comb begin
        n_h         = r_h;
        n_len       = r_len;
        n_k         = r_k;
        n_last      = r_last;
        n_full      = r_full;
        n_fold      = r_fold;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        mix_x       = rotl32(r_h ^ r_k, 13);
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_k    = i_data.key_word & in_mask;
                    n_last = i_data.last;
                    n_full = in_full;
                    n_len  = r_len + (in_full ? 32'd4 : 32'(cnt_sat));
                end
            end
            ST_MIX1, ST_MIX2: begin
                n_k = mul_p;
            end
            ST_ROUND: begin
                n_h = (mix_x << 2) + mix_x + ROUND_ADD;
            end
            ST_TAIL: begin
                n_h = r_h ^ r_k;
            end
            ST_FIN0: begin
                n_h   = (r_h ^ r_len) ^ ((r_h ^ r_len) >> 16);
                n_len = '0;
            end
            ST_FIN1: begin
                n_h = mul_p ^ (mul_p >> 13);
            end
            ST_FIN2: begin
                n_h = mul_p ^ (mul_p >> 16);
            end
            ST_FOLD: begin
                n_fold = fold_h;
            end
            ST_SHARD: begin
                if (out_free) begin
                    n_out.hash_value  = r_h;
                    n_out.shard_index = rem_tmp[1:0];
                    n_out_valid       = 1'b1;
                    n_h               = '0;
                end
            end
            default: begin
                n_h = r_h;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_h         <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_h         <= n_h;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_last <= n_last;
        r_full <= n_full;
        r_fold <= n_fold;
        r_out  <= n_out;
    end

endmodule
